FILE: rtl/assert_macros.svh
// Assertion helpers shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge except while reset is held.
`define PPC_ASSERT(name, clk_s, rst_s, prop, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define PPC_ASSERT_ALWAYS(name, clk_s, prop, msg) \
  name: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

FILE: rtl/ppc_pkg.sv
package ppc_pkg;

  // Number of register stages from accept to result.
  localparam int NUM_STAGES = 6;

  // Screen centre offsets.
  localparam int HALF_WIDTH  = 400;
  localparam int HALF_HEIGHT = 400;

  // Field and datapath widths.
  localparam int COORD_W = 10;                // column and row
  localparam int XEXT_W  = COORD_W + 1;       // column and its neighbours
  localparam int SQ_W    = 2 * COORD_W - 1;   // unsigned square of a neighbour column
  localparam int COEF_W  = 32;                // Q16.16 coefficients
  localparam int LIN_W   = COEF_W + XEXT_W;   // linear term product
  localparam int CURVE_W = 52;                // curve value, below 2^51 in magnitude
  localparam int DIST_W  = CURVE_W + 1;       // signed row distance
  localparam int FRAC_W  = 16;

  localparam logic signed [DIST_W-1:0] ONE_Q16 = DIST_W'(65536);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_QUAD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONST = 2'd2;

  // Register reset values.
  localparam logic signed [COEF_W-1:0] QUAD_RESET  = 32'sd1638;
  localparam logic signed [COEF_W-1:0] LIN_RESET   = 32'sd80609;
  localparam logic signed [COEF_W-1:0] CONST_RESET = 32'sd317273;

  // Stage control handed to the datapath modules.
  typedef struct packed {
    logic [NUM_STAGES:1] load;  // stage register takes a new value
    logic [NUM_STAGES:0] vld;   // request present at the stage input side
  } ctrl_t;

  // Side data carried alongside each request.
  typedef struct packed {
    logic signed [COORD_W-1:0] row;
    logic [COORD_W-1:0]        sx;
    logic [COORD_W-1:0]        sy;
  } meta_t;

endpackage

FILE: rtl/ppc_curve_lane.sv
// Evaluates quad*x^2 + lin*x + const over three register stages.
module ppc_curve_lane (
  input  logic                                 clk,
  input  ppc_pkg::ctrl_t                       ctrl,
  input  logic signed [ppc_pkg::XEXT_W-1:0]    x,
  input  logic signed [ppc_pkg::COEF_W-1:0]    quad_coeff,
  input  logic signed [ppc_pkg::COEF_W-1:0]    lin_coeff,
  input  logic signed [ppc_pkg::COEF_W-1:0]    const_term,
  output logic signed [ppc_pkg::CURVE_W-1:0]   y
);

  logic signed [2*ppc_pkg::XEXT_W-1:0] sq_full;
  logic signed [ppc_pkg::XEXT_W-1:0]   x1;
  logic [ppc_pkg::SQ_W-1:0]            xsq1;
  logic signed [ppc_pkg::CURVE_W-1:0]  quad_prod2;
  logic signed [ppc_pkg::LIN_W-1:0]    lin_prod2;
  logic signed [ppc_pkg::CURVE_W-1:0]  y3;

  // The square is never negative and stays below 2^19.
  assign sq_full = x * x;

  // Stage one: square of the column.
  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      x1   <= x;
      xsq1 <= sq_full[ppc_pkg::SQ_W-1:0];
    end
  end

  // Stage two: the two coefficient products.
  always_ff @(posedge clk) begin
    if (ctrl.load[2]) begin
      quad_prod2 <= quad_coeff * $signed({1'b0, xsq1});
      lin_prod2  <= lin_coeff * x1;
    end
  end

  // Stage three: sum of the terms.
  always_ff @(posedge clk) begin
    if (ctrl.load[3]) begin
      y3 <= quad_prod2 + ppc_pkg::CURVE_W'(lin_prod2) + ppc_pkg::CURVE_W'(const_term);
    end
  end

  assign y = y3;

endmodule

FILE: rtl/ppc_decide.sv
`include "assert_macros.svh"

// Distance tests and the final mark, over three register stages.
module ppc_decide (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ppc_pkg::ctrl_t                       ctrl,
  input  logic signed [ppc_pkg::COORD_W-1:0]   row,
  input  logic signed [ppc_pkg::CURVE_W-1:0]   y0,
  input  logic signed [ppc_pkg::CURVE_W-1:0]   yl,
  input  logic signed [ppc_pkg::CURVE_W-1:0]   yr,
  output logic                                 mark
);

  localparam int DW = ppc_pkg::DIST_W;

  logic signed [DW-1:0] rq;
  logic signed [DW-1:0] d0_4, dn_4, du_4, dl_4, dr_4;
  logic                 turning4, turning5;
  logic [DW-1:0]        a0_5, an_5, au_5, al_5, ar_5;
  logic                 mark6;
  logic                 dist_top;

  // Row as a Q16.16 value.
  assign rq = DW'(row) <<< ppc_pkg::FRAC_W;

  // Stage four: signed distances and the turning point test.
  always_ff @(posedge clk) begin
    if (ctrl.load[4]) begin
      d0_4     <= rq - DW'(y0);
      dn_4     <= (rq - ppc_pkg::ONE_Q16) - DW'(y0);
      du_4     <= (rq + ppc_pkg::ONE_Q16) - DW'(y0);
      dl_4     <= rq - DW'(yl);
      dr_4     <= rq - DW'(yr);
      turning4 <= ((yr > y0) && (y0 < yl)) || ((yr < y0) && (y0 > yl));
    end
  end

  // Stage five: magnitudes.
  always_ff @(posedge clk) begin
    if (ctrl.load[5]) begin
      a0_5     <= d0_4[DW-1] ? -d0_4 : d0_4;
      an_5     <= dn_4[DW-1] ? -dn_4 : dn_4;
      au_5     <= du_4[DW-1] ? -du_4 : du_4;
      al_5     <= dl_4[DW-1] ? -dl_4 : dl_4;
      ar_5     <= dr_4[DW-1] ? -dr_4 : dr_4;
      turning5 <= turning4;
    end
  end

  // Stage six: a tie is never nearer, so every test is strict.
  always_ff @(posedge clk) begin
    if (ctrl.load[6]) begin
      mark6 <= ((a0_5 < an_5) && (a0_5 < au_5)) ||
               ((a0_5 < al_5) && (a0_5 < ar_5) && !turning5);
    end
  end

  assign mark = mark6;

  // Top bit of the vertical distance magnitudes.
  assign dist_top = a0_5[DW-1] | an_5[DW-1] | au_5[DW-1];

  // The vertical distance magnitudes of a real request never reach the sign position.
  `PPC_ASSERT(a_dist_in_range, clk, rst, ctrl.load[5] && ctrl.vld[4] |=> !dist_top, "distance overflow")

endmodule

FILE: rtl/parabola_pixel_classifier_top.sv
// Throughput: one request per cycle while out_stall does not back up the pipe; the
// six stage registers advance independently, so an empty stage is filled even while
// the result stage is held by out_stall. Reset (rst, synchronous, active high) empties
// every stage and loads the coefficient registers with their default values.
`include "assert_macros.svh"

module parabola_pixel_classifier_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [ppc_pkg::COORD_W-1:0]     column,
  input  logic signed [ppc_pkg::COORD_W-1:0]     pixel_row,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   on_curve,
  output logic [ppc_pkg::COORD_W-1:0]            screen_x,
  output logic [ppc_pkg::COORD_W-1:0]            screen_y,
  input  logic                                   cfg_we,
  input  logic [ppc_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [ppc_pkg::COEF_W-1:0]             cfg_data
);

  localparam int NS = ppc_pkg::NUM_STAGES;
  localparam int XW = ppc_pkg::XEXT_W;
  localparam int CW = ppc_pkg::COORD_W;

  logic signed [ppc_pkg::COEF_W-1:0]  quad_coeff, lin_coeff, const_term;
  logic [NS:1]                         vld;
  ppc_pkg::ctrl_t                      ctrl;
  logic [NS+1:1]                       adv;
  ppc_pkg::meta_t                      meta [1:NS];
  ppc_pkg::meta_t                      meta_in;
  logic signed [XW-1:0]                x_mid, x_left, x_right;
  logic signed [ppc_pkg::CURVE_W-1:0]  y_mid, y_left, y_right;
  logic                                mark;

  // Coefficient registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      quad_coeff <= ppc_pkg::QUAD_RESET;
      lin_coeff  <= ppc_pkg::LIN_RESET;
      const_term <= ppc_pkg::CONST_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ppc_pkg::REG_QUAD:  quad_coeff <= cfg_data;
        ppc_pkg::REG_LIN:   lin_coeff  <= cfg_data;
        ppc_pkg::REG_CONST: const_term <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage takes a new request when it is empty or its content moves on.
  always_comb begin
    adv[NS+1] = !out_stall;
    for (int k = NS; k >= 1; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
    ctrl.load = adv[NS:1];
    ctrl.vld  = {vld, in_valid};
  end

  assign in_stall = !adv[1];

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (adv[k]) begin
          vld[k] <= ctrl.vld[k-1];
        end
      end
    end
  end

  // Screen address, wrapped to the field width, and the row travel with the request.
  always_comb begin
    meta_in.row = pixel_row;
    meta_in.sx  = column + CW'(ppc_pkg::HALF_WIDTH);
    meta_in.sy  = CW'(ppc_pkg::HALF_HEIGHT) - pixel_row;
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      meta[1] <= meta_in;
    end
    for (int k = 2; k <= NS; k++) begin
      if (adv[k]) begin
        meta[k] <= meta[k-1];
      end
    end
  end

  // The column and its two neighbours.
  assign x_mid   = XW'(column);
  assign x_left  = x_mid - XW'(1);
  assign x_right = x_mid + XW'(1);

  ppc_curve_lane u_lane_mid (
    .clk        (clk),
    .ctrl       (ctrl),
    .x          (x_mid),
    .quad_coeff (quad_coeff),
    .lin_coeff  (lin_coeff),
    .const_term (const_term),
    .y          (y_mid)
  );

  ppc_curve_lane u_lane_left (
    .clk        (clk),
    .ctrl       (ctrl),
    .x          (x_left),
    .quad_coeff (quad_coeff),
    .lin_coeff  (lin_coeff),
    .const_term (const_term),
    .y          (y_left)
  );

  ppc_curve_lane u_lane_right (
    .clk        (clk),
    .ctrl       (ctrl),
    .x          (x_right),
    .quad_coeff (quad_coeff),
    .lin_coeff  (lin_coeff),
    .const_term (const_term),
    .y          (y_right)
  );

  ppc_decide u_decide (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .row  (meta[3].row),
    .y0   (y_mid),
    .yl   (y_left),
    .yr   (y_right),
    .mark (mark)
  );

  assign out_valid = vld[NS];
  assign on_curve  = mark;
  assign screen_x  = meta[NS].sx;
  assign screen_y  = meta[NS].sy;

  // The input is held back only when every stage is occupied.
  `PPC_ASSERT_ALWAYS(a_stall_only_when_full, clk, in_stall |-> (&vld), "stall with a free stage")
  // An accepted request always lands in the first stage.
  `PPC_ASSERT(a_accept_enters, clk, rst, in_valid && !in_stall |=> vld[1], "request lost at entry")
  // A held third stage keeps its request.
  `PPC_ASSERT(a_hold_keeps, clk, rst, vld[3] && !adv[3] |=> vld[3], "held request dropped")

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  // The spare register index decodes to nothing and must leave the coefficients alone.
  localparam logic [ppc_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int     RESULT_LATENCY = ppc_pkg::NUM_STAGES;
  localparam int     LONG_HOLD      = 120;
  localparam int     RANDOM_PHASES  = 8;
  localparam int     PHASE_PIXELS   = 80;
  localparam longint ONE_ROW        = 64'sd65536;

  typedef struct packed {
    logic                        on_curve;
    logic [ppc_pkg::COORD_W-1:0] screen_x;
    logic [ppc_pkg::COORD_W-1:0] screen_y;
  } pixel_result_t;

  typedef struct {
    int                                 setting;
    logic signed [ppc_pkg::COORD_W-1:0] column;
    logic signed [ppc_pkg::COORD_W-1:0] row;
    bit                                 typed;
    pixel_result_t                      want;
  } pixel_case_t;

  logic                                 clk;
  logic                                 rst;
  logic                                 in_valid;
  logic                                 in_stall;
  logic signed [ppc_pkg::COORD_W-1:0]   column;
  logic signed [ppc_pkg::COORD_W-1:0]   pixel_row;
  logic                                 out_valid;
  logic                                 out_stall;
  logic                                 on_curve;
  logic [ppc_pkg::COORD_W-1:0]          screen_x;
  logic [ppc_pkg::COORD_W-1:0]          screen_y;
  logic                                 cfg_we;
  logic [ppc_pkg::CFG_IDX_W-1:0]        cfg_index;
  logic [ppc_pkg::COEF_W-1:0]           cfg_data;

  // Coefficients as the block should currently hold them.
  logic signed [ppc_pkg::COEF_W-1:0] model_quad  = ppc_pkg::QUAD_RESET;
  logic signed [ppc_pkg::COEF_W-1:0] model_lin   = ppc_pkg::LIN_RESET;
  logic signed [ppc_pkg::COEF_W-1:0] model_const = ppc_pkg::CONST_RESET;

  pixel_result_t expected_pixels[$];
  int            mismatch_count = 0;
  bit            tx_idle_on     = 1'b1;
  bit            rx_idle_on     = 1'b1;
  bit            hold_request   = 1'b0;

  // Coefficient sets for the directed part: reset, flat at zero, flat at half a row,
  // and both extremes.
  logic signed [ppc_pkg::COEF_W-1:0] coef_sets [5][3] = '{
    '{ppc_pkg::QUAD_RESET, ppc_pkg::LIN_RESET, ppc_pkg::CONST_RESET},
    '{32'sd0, 32'sd0, 32'sd0},
    '{32'sd0, 32'sd0, 32'sd32768},
    '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF},
    '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000}
  };

  // Directed pixels. Typed results are the obvious ones: the vertex region under the
  // reset curve, far-off rows, flat curves with exact hits and with distance ties.
  pixel_case_t directed_cases [24] = '{
    '{0, 10'sd0,    10'sd5,    1'b1, '{1'b1, 10'd400, 10'd395}},
    '{0, 10'sd0,    -10'sd400, 1'b1, '{1'b0, 10'd400, 10'd800}},
    '{0, 10'sd0,    10'sd399,  1'b1, '{1'b0, 10'd400, 10'd1}},
    '{0, -10'sd400, -10'sd400, 1'b0, '0},
    '{0, 10'sd399,  10'sd399,  1'b0, '0},
    '{0, 10'h200,   10'h200,   1'b0, '0},
    '{0, 10'sd511,  10'sd511,  1'b0, '0},
    '{0, -10'sd1,   10'sd4,    1'b0, '0},
    '{0, 10'sd1,    10'sd6,    1'b0, '0},
    '{1, 10'sd0,    10'sd0,    1'b1, '{1'b1, 10'd400, 10'd400}},
    '{1, 10'sd0,    10'sd1,    1'b1, '{1'b0, 10'd400, 10'd399}},
    '{1, 10'h200,   10'sd0,    1'b1, '{1'b1, 10'd912, 10'd400}},
    '{1, 10'sd511,  -10'sd1,   1'b1, '{1'b0, 10'd911, 10'd401}},
    '{2, 10'sd0,    10'sd0,    1'b1, '{1'b0, 10'd400, 10'd400}},
    '{2, 10'sd100,  10'sd1,    1'b1, '{1'b0, 10'd500, 10'd399}},
    '{2, 10'sd0,    -10'sd1,   1'b1, '{1'b0, 10'd400, 10'd401}},
    '{3, 10'sd0,    10'sd0,    1'b0, '0},
    '{3, 10'h200,   10'sd511,  1'b0, '0},
    '{3, 10'sd511,  10'h200,   1'b0, '0},
    '{3, 10'sd5,    10'sd399,  1'b0, '0},
    '{4, 10'sd0,    10'sd0,    1'b0, '0},
    '{4, 10'h200,   10'h200,   1'b0, '0},
    '{4, 10'sd511,  10'sd511,  1'b0, '0},
    '{4, 10'sd1,    -10'sd400, 1'b0, '0}
  };

  parabola_pixel_classifier_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .column    (column),
    .pixel_row (pixel_row),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .on_curve  (on_curve),
    .screen_x  (screen_x),
    .screen_y  (screen_y),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Curve height at a column, exact in Q16.16.
  function automatic longint curve_value(input longint x);
    return longint'(model_quad) * x * x + longint'(model_lin) * x + longint'(model_const);
  endfunction

  function automatic longint abs_gap(input longint a, input longint b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Expected mark and screen address of one pixel under the current coefficients.
  function automatic pixel_result_t classify_pixel(
      input logic signed [ppc_pkg::COORD_W-1:0] col,
      input logic signed [ppc_pkg::COORD_W-1:0] prow);
    longint        x;
    longint        rq;
    longint        y0;
    longint        yl;
    longint        yr;
    longint        d0;
    logic          vert_min;
    logic          horiz_min;
    logic          turning;
    pixel_result_t res;
    x  = longint'(col);
    rq = longint'(prow) * ONE_ROW;
    y0 = curve_value(x);
    yl = curve_value(x - 1);
    yr = curve_value(x + 1);
    d0 = abs_gap(rq, y0);
    // A tie in distance never counts as nearer.
    vert_min  = (d0 < abs_gap(rq - ONE_ROW, y0)) && (d0 < abs_gap(rq + ONE_ROW, y0));
    horiz_min = (d0 < abs_gap(rq, yl)) && (d0 < abs_gap(rq, yr));
    turning   = ((yr > y0) && (y0 < yl)) || ((yr < y0) && (y0 > yl));
    res.on_curve = vert_min || (horiz_min && !turning);
    res.screen_x = ppc_pkg::COORD_W'(x + ppc_pkg::HALF_WIDTH);
    res.screen_y = ppc_pkg::COORD_W'(ppc_pkg::HALF_HEIGHT - longint'(prow));
    return res;
  endfunction

  // A row within three of the curve at this column, or any row if the curve is off range.
  function automatic logic signed [ppc_pkg::COORD_W-1:0] row_near_curve(
      input logic signed [ppc_pkg::COORD_W-1:0] col);
    longint target;
    int     offset;
    offset = $urandom_range(0, 6);
    target = (curve_value(longint'(col)) >>> ppc_pkg::FRAC_W) + longint'(offset) - 3;
    if (target < -512 || target > 511) return ppc_pkg::COORD_W'($urandom);
    return ppc_pkg::COORD_W'(target);
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // One register write; the expected coefficients follow it.
  task automatic write_register(input logic [ppc_pkg::CFG_IDX_W-1:0] idx,
                                input logic [ppc_pkg::COEF_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ppc_pkg::REG_QUAD:  model_quad  = data;
      ppc_pkg::REG_LIN:   model_lin   = data;
      ppc_pkg::REG_CONST: model_const = data;
      default: ;
    endcase
  endtask

  task automatic load_coefficients(input logic [ppc_pkg::COEF_W-1:0] quad,
                                   input logic [ppc_pkg::COEF_W-1:0] lin,
                                   input logic [ppc_pkg::COEF_W-1:0] cst);
    write_register(ppc_pkg::REG_QUAD, quad);
    write_register(ppc_pkg::REG_LIN, lin);
    write_register(ppc_pkg::REG_CONST, cst);
    write_register(REG_SPARE, $urandom);
  endtask

  // Offer one request, entered and left at a falling edge. Valid stays high across
  // back-to-back requests.
  task automatic send_pixel(input logic signed [ppc_pkg::COORD_W-1:0] col,
                            input logic signed [ppc_pkg::COORD_W-1:0] prow,
                            input bit typed,
                            input pixel_result_t want);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    column    <= col;
    pixel_row <= prow;
    in_valid  <= 1'b1;
    do @(posedge clk); while (in_stall);
    expected_pixels.push_back(typed ? want : classify_pixel(col, prow));
    @(negedge clk);
  endtask

  // Stop offering, let every outstanding request come out, then let the pipe settle.
  task automatic drain_requests();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (RESULT_LATENCY + 2) @(negedge clk);
  endtask

  // Receiver: stalls for a drawn number of cycles before each result, or for a long
  // stretch when asked, so that the pipe backs up into the input.
  initial begin : receiver
    int hold_cycles;
    out_stall = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      hold_cycles = rx_idle_on ? $urandom_range(0, 11) : 0;
      if (hold_request) begin
        hold_request = 1'b0;
        hold_cycles  = LONG_HOLD;
      end
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin : result_check
    pixel_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected result x=%0d y=%0d", screen_x, screen_y));
      end else begin
        want = expected_pixels.pop_front();
        if (on_curve !== want.on_curve)
          report_mismatch($sformatf("on_curve %b, expected %b at x=%0d y=%0d",
                                    on_curve, want.on_curve, want.screen_x, want.screen_y));
        if (screen_x !== want.screen_x)
          report_mismatch($sformatf("screen_x %0d, expected %0d", screen_x, want.screen_x));
        if (screen_y !== want.screen_y)
          report_mismatch($sformatf("screen_y %0d, expected %0d", screen_y, want.screen_y));
      end
    end
  end

  // Main sequence: reset, directed table, then random phases.
  initial begin : stimulus
    int                                 setting;
    int                                 pick;
    logic signed [ppc_pkg::COORD_W-1:0] col;
    logic signed [ppc_pkg::COORD_W-1:0] prow;
    logic [ppc_pkg::COEF_W-1:0]         quad;
    logic [ppc_pkg::COEF_W-1:0]         lin;
    logic [ppc_pkg::COEF_W-1:0]         cst;
    rst       = 1'b1;
    in_valid  = 1'b0;
    column    = '0;
    pixel_row = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed table; a change of coefficient set waits for the pipe to empty.
    setting = 0;
    foreach (directed_cases[i]) begin
      if (directed_cases[i].setting != setting) begin
        drain_requests();
        setting = directed_cases[i].setting;
        load_coefficients(coef_sets[setting][0], coef_sets[setting][1],
                          coef_sets[setting][2]);
      end
      send_pixel(directed_cases[i].column, directed_cases[i].row,
                 directed_cases[i].typed, directed_cases[i].want);
    end
    drain_requests();

    // Random phases: mostly curves that cross the screen, one with raw 32-bit values.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      tx_idle_on = (phase % 3) != 1;
      rx_idle_on = (phase % 4) != 2;
      if (phase == 5) begin
        quad = $urandom;
        lin  = $urandom;
        cst  = $urandom;
      end else begin
        quad = $urandom_range(0, 4096);
        lin  = $urandom_range(0, 262144);
        cst  = $urandom_range(0, 200 * 65536);
        if ($urandom_range(0, 1)) quad = -quad;
        if ($urandom_range(0, 1)) lin = -lin;
        if ($urandom_range(0, 1)) cst = -cst;
      end
      load_coefficients(quad, lin, cst);

      // Back-to-back requests against a long receiver hold fill the pipe.
      if (phase == 3) begin
        tx_idle_on   = 1'b0;
        hold_request = 1'b1;
      end

      for (int n = 0; n < PHASE_PIXELS; n++) begin
        pick = $urandom_range(0, 9);
        col  = (pick < 8) ? ppc_pkg::COORD_W'($urandom_range(0, 799) - 400)
                          : ppc_pkg::COORD_W'($urandom);
        pick = $urandom_range(0, 9);
        prow = (pick < 7) ? row_near_curve(col) : ppc_pkg::COORD_W'($urandom);
        send_pixel(col, prow, 1'b0, '0);
      end
      drain_requests();
    end

    repeat (4 * RESULT_LATENCY) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin : watchdog
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
